>>> rtl/lazy_mod_range_multiply_sum_tree_macros.svh
// Assertion macros for the modular range multiply / range sum block.
`ifndef LAZY_MOD_RANGE_MULTIPLY_SUM_TREE_MACROS_SVH
`define LAZY_MOD_RANGE_MULTIPLY_SUM_TREE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LMRMS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define LMRMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/lmrms_pkg.sv
// Shared constants for the modular range multiply / range sum block.
`timescale 1ns / 1ps
package lmrms_pkg;
    localparam int VAL_W  = 30;
    localparam int IDX_W  = 11;
    localparam int ADDR_W = 10;
    localparam int DEPTH  = 1024;
    localparam int CNT_W  = 5;

    localparam logic [VAL_W-1:0] PRIME    = 30'd1000000007;
    localparam logic [IDX_W-1:0] MAX_LEN  = 11'd1024;

    localparam logic [1:0] CMD_ASSIGN = 2'd0;
    localparam logic [1:0] CMD_MUL    = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;
endpackage

>>> rtl/lmrms_mulmod.sv
// Bit-serial modular multiplier: a doubling phase and a conditional-add phase per multiplier bit.
`timescale 1ns / 1ps
module lmrms_mulmod
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lmrms_pkg::VAL_W-1:0]   a,
    input  logic [lmrms_pkg::VAL_W-1:0]   b,
    output logic                          done,
    output logic [lmrms_pkg::VAL_W-1:0]   product
);
    logic                          busy_reg;
    logic                          phase_reg;
    logic                          done_reg;
    logic [lmrms_pkg::CNT_W-1:0]   cnt_reg;
    logic [lmrms_pkg::VAL_W-1:0]   acc_reg;
    logic [lmrms_pkg::VAL_W-1:0]   a_reg;
    logic [lmrms_pkg::VAL_W-1:0]   b_reg;
    logic [lmrms_pkg::VAL_W:0]     sum_wide;
    logic [lmrms_pkg::VAL_W:0]     sum_red;
    logic [lmrms_pkg::VAL_W-1:0]   acc_next;

    // double on phase 0, conditional add on phase 1
    always_comb
    begin
        if (!phase_reg)
        begin
            sum_wide = {acc_reg, 1'b0};
        end
        else
        begin
            sum_wide = {1'b0, acc_reg} + {1'b0, (b_reg[lmrms_pkg::VAL_W-1] ? a_reg : '0)};
        end
        sum_red = sum_wide - {1'b0, lmrms_pkg::PRIME};
        acc_next = (sum_wide >= {1'b0, lmrms_pkg::PRIME}) ? sum_red[lmrms_pkg::VAL_W-1:0]
                                                          : sum_wide[lmrms_pkg::VAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
                cnt_reg   <= '0;
            end
            else if (busy_reg)
            begin
                phase_reg <= ~phase_reg;
                if (phase_reg)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == lmrms_pkg::CNT_W'(lmrms_pkg::VAL_W - 1))
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            if (phase_reg)
            begin
                b_reg <= {b_reg[lmrms_pkg::VAL_W-2:0], 1'b0};
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

>>> rtl/lazy_mod_range_multiply_sum_tree.sv
// Top level: modular range multiply / range sum store over up to 1024 positions.
// Operation: after reset and after every length write a clearing pass over all 1024
// entries runs, with input not ready. An assign is written as it is taken. A query
// sums each position of the clipped range in turn (an empty range returns 0), and
// waits while an earlier result still sits unread in the output register. A
// multiply reads, multiplies and writes back each position of the range in turn,
// using the bit-serial modular multiplier and the single-port element store.
// Results for queries sit in an output register; the next item is taken meanwhile.
`timescale 1ns / 1ps
`include "lazy_mod_range_multiply_sum_tree_macros.svh"
module lazy_mod_range_multiply_sum_tree
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] cmd, [12:2] left_index, [23:13] right_index, [53:24] operand_value
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [29:0] range_sum
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data
);
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]                          state_reg;
    logic [lmrms_pkg::IDX_W-1:0]         len_reg;
    logic [lmrms_pkg::IDX_W-1:0]         idx_reg;
    logic [lmrms_pkg::IDX_W-1:0]         end_reg;
    logic [lmrms_pkg::ADDR_W-1:0]        clr_reg;
    logic                                is_mul_reg;
    logic [lmrms_pkg::VAL_W-1:0]         val_reg;
    logic [lmrms_pkg::VAL_W-1:0]         sum_reg;
    logic [lmrms_pkg::VAL_W-1:0]         rdata_reg;
    logic                                out_valid_reg;
    logic [lmrms_pkg::VAL_W-1:0]         out_data_reg;

    logic [lmrms_pkg::VAL_W-1:0]         mem [lmrms_pkg::DEPTH];

    logic [1:0]                          in_cmd;
    logic [lmrms_pkg::IDX_W-1:0]         in_left;
    logic [lmrms_pkg::IDX_W-1:0]         in_right;
    logic [lmrms_pkg::VAL_W-1:0]         in_val;
    logic [lmrms_pkg::VAL_W-1:0]         val_red;
    logic [lmrms_pkg::IDX_W-1:0]         left_lo;
    logic [lmrms_pkg::IDX_W-1:0]         left_asn;
    logic [lmrms_pkg::IDX_W-1:0]         right_cl;
    logic [lmrms_pkg::IDX_W-1:0]         cfg_len;
    logic [lmrms_pkg::IDX_W-1:0]         idx_m1;
    logic [lmrms_pkg::IDX_W-1:0]         asn_m1;
    logic [lmrms_pkg::VAL_W:0]           add_wide;
    logic [lmrms_pkg::VAL_W:0]           add_sub;
    logic [lmrms_pkg::VAL_W-1:0]         add_mod;
    logic                                in_fire;
    logic                                cfg_fire;
    logic                                out_free;
    logic                                we;
    logic [lmrms_pkg::ADDR_W-1:0]        waddr;
    logic [lmrms_pkg::VAL_W-1:0]         wdata;
    logic                                mm_start;
    logic                                mm_done;
    logic [lmrms_pkg::VAL_W-1:0]         mm_product;

    assign in_cmd   = s_axis_tdata[1:0];
    assign in_left  = s_axis_tdata[12:2];
    assign in_right = s_axis_tdata[23:13];
    assign in_val   = s_axis_tdata[53:24];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_fire      = cfg_valid && cfg_ready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_data_reg};

    always_comb
    begin
        val_red  = (in_val >= lmrms_pkg::PRIME) ? in_val - lmrms_pkg::PRIME : in_val;
        left_lo  = (in_left == '0) ? lmrms_pkg::IDX_W'(1) : in_left;
        left_asn = (left_lo > len_reg) ? len_reg : left_lo;
        right_cl = (in_right > len_reg) ? len_reg : in_right;
        asn_m1   = left_asn - lmrms_pkg::IDX_W'(1);
        idx_m1   = idx_reg - lmrms_pkg::IDX_W'(1);
        if (cfg_data == '0)
        begin
            cfg_len = lmrms_pkg::IDX_W'(1);
        end
        else if (cfg_data > lmrms_pkg::MAX_LEN)
        begin
            cfg_len = lmrms_pkg::MAX_LEN;
        end
        else
        begin
            cfg_len = cfg_data;
        end
        add_wide = {1'b0, sum_reg} + {1'b0, rdata_reg};
        add_sub  = add_wide - {1'b0, lmrms_pkg::PRIME};
        add_mod  = (add_wide >= {1'b0, lmrms_pkg::PRIME}) ? add_sub[lmrms_pkg::VAL_W-1:0]
                                                          : add_wide[lmrms_pkg::VAL_W-1:0];
    end

    // single write port: clear, assign, multiply writeback
    always_comb
    begin
        we    = 1'b0;
        waddr = idx_m1[lmrms_pkg::ADDR_W-1:0];
        wdata = mm_product;
        if (state_reg == S_CLEAR)
        begin
            we    = 1'b1;
            waddr = clr_reg;
            wdata = '0;
        end
        else if (in_fire && in_cmd == lmrms_pkg::CMD_ASSIGN)
        begin
            we    = 1'b1;
            waddr = asn_m1[lmrms_pkg::ADDR_W-1:0];
            wdata = val_red;
        end
        else if (state_reg == S_MUL && mm_done)
        begin
            we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[idx_m1[lmrms_pkg::ADDR_W-1:0]];
    end

    assign mm_start = (state_reg == S_LOAD) && is_mul_reg;

    lmrms_mulmod u_mulmod
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .a       (rdata_reg),
        .b       (val_reg),
        .done    (mm_done),
        .product (mm_product)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_OUT && out_free && !cfg_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            len_reg       <= lmrms_pkg::MAX_LEN;
            clr_reg       <= '0;
        end
        else
        begin
            if (cfg_fire)
            begin
                len_reg   <= cfg_len;
                clr_reg   <= '0;
                state_reg <= S_CLEAR;
            end
            else
            begin
                unique case (state_reg)
                    S_CLEAR:
                    begin
                        clr_reg <= clr_reg + 1'b1;
                        if (clr_reg == lmrms_pkg::ADDR_W'(lmrms_pkg::DEPTH - 1))
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    S_IDLE:
                    begin
                        if (in_fire && (in_cmd == lmrms_pkg::CMD_MUL
                                        || in_cmd == lmrms_pkg::CMD_QUERY))
                        begin
                            if (left_lo <= right_cl)
                            begin
                                state_reg <= S_READ;
                            end
                            else if (in_cmd == lmrms_pkg::CMD_QUERY)
                            begin
                                state_reg <= S_OUT;
                            end
                        end
                    end
                    S_READ:
                    begin
                        state_reg <= S_LOAD;
                    end
                    S_LOAD:
                    begin
                        if (is_mul_reg)
                        begin
                            state_reg <= S_MUL;
                        end
                        else if (idx_reg == end_reg)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                    S_MUL:
                    begin
                        if (mm_done)
                        begin
                            state_reg <= (idx_reg == end_reg) ? S_IDLE : S_READ;
                        end
                    end
                    S_OUT:
                    begin
                        if (out_free)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            idx_reg    <= left_lo;
            end_reg    <= right_cl;
            val_reg    <= val_red;
            is_mul_reg <= (in_cmd == lmrms_pkg::CMD_MUL);
            sum_reg    <= '0;
        end
        else if (state_reg == S_LOAD && !is_mul_reg)
        begin
            sum_reg <= add_mod;
            if (idx_reg != end_reg)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
        else if (state_reg == S_MUL && mm_done && idx_reg != end_reg)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_data_reg <= sum_reg;
        end
    end

    `LMRMS_ASSERT_NOW(a_done_in_mul, mm_done, state_reg == S_MUL)
    `LMRMS_ASSERT_NOW(a_idx_in_range, state_reg == S_LOAD,
        idx_reg <= end_reg && idx_reg != '0 && idx_reg <= len_reg)
    `LMRMS_ASSERT_NOW(a_out_from_seq, $rose(out_valid_reg), $past(state_reg) == S_OUT)
    `LMRMS_ASSERT_NEXT(a_clear_exit, state_reg == S_CLEAR && clr_reg != '1 && !cfg_fire,
        state_reg == S_CLEAR)
endmodule

>>> tb/sv/tb.sv
// Testbench for the modular range multiply / range sum store.
`timescale 1ns / 1ps
module tb;
    typedef struct packed {
        logic [29:0] operand;
        logic [10:0] right_idx;
        logic [10:0] left_idx;
        logic [1:0]  cmd;
    } request_t;

    localparam longint unsigned P = 64'd1000000007;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [10:0] cfg_data;

    request_t        pending[$];
    request_t        in_flight;
    bit              taken;
    bit              calm;
    int              n_sent;
    logic [29:0]     sums_due[$];
    longint unsigned elem_val[1:1024];
    int              len_now;
    int              errors;

    lazy_mod_range_multiply_sum_tree uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic clear_array(input int n);
        len_now = n;
        for (int i = 1; i <= 1024; i++)
            elem_val[i] = 0;
    endtask

    task automatic predict_request(input request_t rq);
        int              l;
        int              r;
        longint unsigned v;
        longint unsigned acc;
        l = rq.left_idx;
        r = rq.right_idx;
        v = longint'(rq.operand) % P;
        acc = 0;
        if (rq.cmd == lmrms_pkg::CMD_ASSIGN)
        begin
            if (l < 1)
                l = 1;
            if (l > len_now)
                l = len_now;
            elem_val[l] = v;
        end
        else if (rq.cmd != lmrms_pkg::CMD_NONE)
        begin
            if (l < 1)
                l = 1;
            if (r > len_now)
                r = len_now;
            for (int i = l; i <= r; i++)
                if (rq.cmd == lmrms_pkg::CMD_MUL)
                    elem_val[i] = (elem_val[i] * v) % P;
                else
                    acc = (acc + elem_val[i]) % P;
            if (rq.cmd == lmrms_pkg::CMD_QUERY)
                sums_due.push_back(acc[29:0]);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            if (cfg_data == 0)
                clear_array(1);
            else if (cfg_data > 1024)
                clear_array(1024);
            else
                clear_array(int'(cfg_data));
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_request(in_flight);
            taken = 1'b1;
            n_sent++;
            calm = (n_sent >= 700 && n_sent < 1000);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || taken))
        begin
            taken = 1'b0;
            if (pending.size() != 0 && (calm || $urandom_range(0, 99) >= 33))
            begin
                in_flight = pending.pop_front();
                s_axis_tdata <= {2'b00, in_flight};
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
        if (rst_n)
            m_axis_tready <= calm || $urandom_range(0, 99) >= 33;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (sums_due.size() == 0)
            begin
                $error("range_sum: none expected, actual %0d", m_axis_tdata[29:0]);
                errors++;
            end
            else if (m_axis_tdata[29:0] !== sums_due[0])
            begin
                $error("range_sum: expected %0d, actual %0d", sums_due[0],
                       m_axis_tdata[29:0]);
                errors++;
                void'(sums_due.pop_front());
            end
            else
                void'(sums_due.pop_front());
        end
    end

    function automatic request_t mk(input logic [1:0] c, input int l, input int r,
                                    input logic [29:0] v);
        request_t rq;
        rq.cmd = c;
        rq.left_idx = 11'(l);
        rq.right_idx = 11'(r);
        rq.operand = v;
        return rq;
    endfunction

    function automatic logic [29:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 30'($urandom_range(0, 3));
            1: return 30'(30'd1000000007 - $urandom_range(0, 3));
            2: return 30'(30'h3FFFFFFF - $urandom_range(0, 3));
            default: return 30'($urandom());
        endcase
    endfunction

    function automatic int rand_pos(input int n);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? 0 : $urandom_range(n, 2047);
        return $urandom_range(1, n);
    endfunction

    function automatic request_t rand_request(input int n);
        int sel;
        int l;
        int r;
        sel = $urandom_range(0, 99);
        l = rand_pos(n);
        r = rand_pos(n);
        if (sel < 35)
            return mk(lmrms_pkg::CMD_ASSIGN, l, r, rand_operand());
        if (sel < 60)
        begin
            // keep multiply spans short on long arrays
            if (n > 64 && $urandom_range(0, 9) != 0)
                r = l + $urandom_range(0, 7);
            else if (n > 64)
                r = l - 1;
            return mk(lmrms_pkg::CMD_MUL, l, r, rand_operand());
        end
        if (sel < 95)
            return mk(lmrms_pkg::CMD_QUERY, l, r, rand_operand());
        return mk(lmrms_pkg::CMD_NONE, l, r, rand_operand());
    endfunction

    task automatic run_phase(input int cfg, input int count);
        int n;
        while (pending.size() != 0 || sums_due.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (cfg >= 0)
        begin
            @(negedge clk);
            cfg_data <= 11'(cfg);
            cfg_valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg_ready);
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
        n = len_now;
        for (int i = 0; i < count; i++)
            pending.push_back(rand_request(n));
        pending.push_back(mk(lmrms_pkg::CMD_QUERY, 0, 2047, 30'd0));
    endtask

    initial
    begin
        errors = 0;
        calm = 1'b0;
        n_sent = 0;
        taken = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        clear_array(1024);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        pending.push_back(mk(lmrms_pkg::CMD_ASSIGN, 0, 0, 30'h3FFFFFFF));
        pending.push_back(mk(lmrms_pkg::CMD_ASSIGN, 2047, 1, 30'd1000000007));
        pending.push_back(mk(lmrms_pkg::CMD_ASSIGN, 1023, 0, 30'd1000000006));
        pending.push_back(mk(lmrms_pkg::CMD_ASSIGN, 1022, 0, 30'd123456789));
        pending.push_back(mk(lmrms_pkg::CMD_QUERY, 0, 2047, 30'd0));
        pending.push_back(mk(lmrms_pkg::CMD_MUL, 1020, 2047, 30'd1000000006));
        pending.push_back(mk(lmrms_pkg::CMD_MUL, 0, 1, 30'h3FFFFFFF));
        pending.push_back(mk(lmrms_pkg::CMD_MUL, 9, 3, 30'd5));
        pending.push_back(mk(lmrms_pkg::CMD_QUERY, 1, 1, 30'd0));
        pending.push_back(mk(lmrms_pkg::CMD_QUERY, 1021, 2047, 30'd0));
        pending.push_back(mk(lmrms_pkg::CMD_QUERY, 5, 3, 30'd0));
        pending.push_back(mk(lmrms_pkg::CMD_NONE, 1, 1024, 30'd7));
        pending.push_back(mk(lmrms_pkg::CMD_MUL, 1024, 1024, 30'd0));
        pending.push_back(mk(lmrms_pkg::CMD_QUERY, 1000, 1024, 30'd0));
        run_phase(-1, 600);
        run_phase(0, 100);
        run_phase(8, 300);
        pending.push_back(mk(lmrms_pkg::CMD_ASSIGN, 3, 0, 30'd999999999));
        pending.push_back(mk(lmrms_pkg::CMD_MUL, 0, 2047, 30'd1000000005));
        pending.push_back(mk(lmrms_pkg::CMD_QUERY, 0, 2047, 30'd0));
        run_phase(2047, 300);
        run_phase($urandom_range(2, 200), 250);

        while (pending.size() != 0 || sums_due.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
